// File: src/generational_handle_table_top_defines.svh
// ----------------------------------------------------------------------------
// Generational handle table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ght_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle table package
// Handle layout, record constants, action/status codes and sequencer states.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int unsigned SLOTS_DEF  = 1024;
  localparam int unsigned SLOTS_MAX  = 32767;

  // Handle layout: slot in [15:0], generation in [27:16], type in [31:28]
  localparam int unsigned HDL_W      = 32;
  localparam int unsigned HSLOT_W    = 16;
  localparam int unsigned GEN_W      = 12;
  localparam int unsigned GEN_LSB    = 16;
  localparam int unsigned TYPE_W     = 4;
  localparam int unsigned TYPE_LSB   = 28;

  localparam logic [TYPE_W-1:0] HANDLE_KIND = 4'd2;

  localparam int unsigned WC_W       = 8;
  localparam logic [WC_W-1:0] WORK_INIT = 8'd2;

  localparam int unsigned REF_W      = 64;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LREAD,
    S_MOVE,
    S_FREE
  } state_e;

endpackage

// File: src/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// Generational handle table
// Slot map with generational handles over a densely packed record array,
// built around a slot memory and a record memory.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   -------   ---------  -------------------------  ---------------------------
//   in        sink       in_valid_i / in_stall_o    action, handle, dependency,
//                                                   entry_ref, args_ref
//   out       source     out_valid_o / out_stall_i  status, new_handle,
//                                                   packed_position, dependency_out,
//                                                   work_count_out, entry_out, args_out
//   cfg       sink       live_limit_we_i            live_limit_i
//
// Each item steps through the sequencer: allocate reads the slot, then writes; lookup and
// delete read the slot, then on a hit the record memory, and delete then moves and frees.
// No clearing pass after reset: a fill mark over fresh slots stands for the reset
// contents of the slot memory, so items are taken straight out of reset.
// The output register holds one result; the next item is taken while it waits,
// and a stalled result holds that item's last step until the transfer.
// ----------------------------------------------------------------------------
module generational_handle_table_top import ght_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned SW   = $clog2(SLOTS),
  localparam int unsigned PW   = $clog2(SLOTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 live_limit_we_i,
  input  logic [SW-1:0]        live_limit_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [HDL_W-1:0]     handle_i,
  input  logic [HDL_W-1:0]     dependency_i,
  input  logic [REF_W-1:0]     entry_ref_i,
  input  logic [REF_W-1:0]     args_ref_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [HDL_W-1:0]     new_handle_o,
  output logic [PW-1:0]        packed_position_o,
  output logic [HDL_W-1:0]     dependency_out_o,
  output logic [WC_W-1:0]      work_count_out_o,
  output logic [REF_W-1:0]     entry_out_o,
  output logic [REF_W-1:0]     args_out_o
);

  `include "generational_handle_table_top_defines.svh"

  localparam logic [PW-1:0]        POS_INVALID = PW'(SLOTS);
  localparam logic [PW-1:0]        SLOTS_PW    = PW'(SLOTS);
  localparam logic [SW:0]          LIMIT_MAX   = (SW+1)'(SLOTS - 1);
  localparam logic [HSLOT_W:0]     SLOTS_HS    = (HSLOT_W+1)'(SLOTS);

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [PW-1:0]    pos;
    logic [SW-1:0]    nxt;
  } slot_ent_t;

  typedef struct packed {
    logic [SW-1:0]    owner;
    logic [HDL_W-1:0] dep;
    logic [WC_W-1:0]  wc;
    logic [REF_W-1:0] ent;
    logic [REF_W-1:0] arg;
  } rec_t;

  // Memories
  slot_ent_t slot_mem [SLOTS];
  rec_t      rec_mem  [SLOTS];

  // Sequencer and table control state
  state_e          state_q, state_d;
  logic [SW-1:0]   limit_q;
  logic [PW-1:0]   live_q, live_d;
  logic [PW-1:0]   hw_q, hw_d;       // fill mark: slots below it have been handed out
  logic [SW-1:0]   fhead_q, fhead_d; // freed-slot list, hw_q - live_q entries long
  logic [SW-1:0]   ftail_q, ftail_d;
  logic            out_valid_q, out_valid_d;

  // Payload registers
  logic [1:0]       act_q;
  logic [HDL_W-1:0] hdl_q;
  logic [HDL_W-1:0] dep_q;
  logic [REF_W-1:0] ent_q;
  logic [REF_W-1:0] arg_q;
  logic [SW-1:0]    hole_q;
  slot_ent_t        srd_q;
  rec_t             rrd_q;

  status_e          out_status_q;
  logic [HDL_W-1:0] out_handle_q;
  logic [PW-1:0]    out_pos_q;
  rec_t             out_rec_q;

  // Memory ports
  logic            sm_re, sm_we_gen, sm_we_pos, sm_we_nxt;
  logic [SW-1:0]   sm_raddr, sm_waddr;
  slot_ent_t       sm_wdata;
  logic            rm_re, rm_we;
  logic [SW-1:0]   rm_raddr, rm_waddr;
  rec_t            rm_wdata;

  // Output load
  logic            ld_out;
  status_e         o_status;
  logic [HDL_W-1:0] o_handle;
  logic [PW-1:0]   o_pos;
  rec_t            o_rec;
  logic            hole_ld;

  // Decode
  logic                 in_accept, out_free;
  logic [HSLOT_W-1:0]   hslot;
  logic [SW-1:0]        hs;
  logic                 in_range, touched, found, full, fresh;
  logic [GEN_W-1:0]     gen_cur, a_gen;
  logic [PW-1:0]        pos_cur;
  logic [SW-1:0]        a_slot, last;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign hslot    = hdl_q[HSLOT_W-1:0];
  assign hs       = hslot[SW-1:0];
  assign in_range = {1'b0, hslot} < SLOTS_HS;
  assign touched  = PW'(hs) < hw_q;
  assign gen_cur  = touched ? srd_q.gen : '0;
  assign pos_cur  = touched ? srd_q.pos : POS_INVALID;
  assign found    = in_range && (gen_cur == hdl_q[GEN_LSB +: GEN_W]) && (pos_cur < live_q);

  assign full     = live_q >= PW'(limit_q);
  assign fresh    = hw_q != SLOTS_PW;
  assign a_slot   = fresh ? hw_q[SW-1:0] : fhead_q;
  assign a_gen    = (fresh ? '0 : srd_q.gen) + 1'b1; // wraps at 4096
  assign last     = SW'(live_q - 1'b1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (act_q)
          ACT_DELETE: begin
            if (found)         state_d = S_MOVE;
            else if (out_free) state_d = S_IDLE;
          end
          ACT_LOOKUP: begin
            if (found)         state_d = S_LREAD;
            else if (out_free) state_d = S_IDLE;
          end
          default: begin
            if (out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_LREAD: begin
        if (out_free) state_d = S_IDLE;
      end
      S_MOVE: begin
        state_d = S_FREE;
      end
      S_FREE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    sm_re     = in_accept;
    sm_raddr  = (action_i == ACT_ALLOC) ? a_slot : handle_i[SW-1:0];
    sm_we_gen = 1'b0;
    sm_we_pos = 1'b0;
    sm_we_nxt = 1'b0;
    sm_waddr  = hs;
    sm_wdata  = '{gen: a_gen, pos: live_q, nxt: hs};
    rm_re     = 1'b0;
    rm_raddr  = last;
    rm_we     = 1'b0;
    rm_waddr  = live_q[SW-1:0];
    rm_wdata  = '{owner: a_slot, dep: dep_q, wc: WORK_INIT, ent: ent_q, arg: arg_q};
    hole_ld   = 1'b0;
    live_d    = live_q;
    hw_d      = hw_q;
    fhead_d   = fhead_q;
    ftail_d   = ftail_q;
    ld_out    = 1'b0;
    o_status  = ST_NOT_FOUND;
    o_handle  = '0;
    o_pos     = POS_INVALID;
    o_rec     = '0;

    case (state_q)
      S_EXEC: begin
        case (act_q)
          ACT_ALLOC: begin
            if (out_free) begin
              ld_out = 1'b1;
              if (full) begin
                o_status = ST_FULL;
              end else begin
                o_status  = ST_OK;
                o_handle  = {HANDLE_KIND, a_gen, HSLOT_W'(a_slot)};
                sm_we_gen = 1'b1;
                sm_we_pos = 1'b1;
                sm_waddr  = a_slot;
                rm_we     = 1'b1;
                live_d    = live_q + 1'b1;
                if (fresh) hw_d = hw_q + 1'b1;
                else       fhead_d = srd_q.nxt;
              end
            end
          end
          ACT_DELETE: begin
            if (found) begin
              rm_re   = 1'b1;
              rm_raddr = last;
              hole_ld = 1'b1;
              // append the freed slot to the freed-slot list
              if (hw_q == live_q) begin
                fhead_d = hs;
              end else begin
                sm_we_nxt = 1'b1;
                sm_waddr  = ftail_q;
              end
              ftail_d = hs;
            end else if (out_free) begin
              ld_out = 1'b1;
            end
          end
          ACT_LOOKUP: begin
            if (found) begin
              rm_re    = 1'b1;
              rm_raddr = pos_cur[SW-1:0];
              hole_ld  = 1'b1;
            end else if (out_free) begin
              ld_out = 1'b1;
            end
          end
          default: begin
            if (out_free) ld_out = 1'b1;
          end
        endcase
      end
      S_LREAD: begin
        if (out_free) begin
          ld_out   = 1'b1;
          o_status = ST_OK;
          o_pos    = PW'(hole_q);
          o_rec    = rrd_q;
        end
      end
      S_MOVE: begin
        // last record fills the hole; repoint its owner unless it is the deleted slot
        rm_we     = 1'b1;
        rm_waddr  = hole_q;
        rm_wdata  = rrd_q;
        sm_we_pos = (rrd_q.owner != hs);
        sm_waddr  = rrd_q.owner;
        sm_wdata.pos = PW'(hole_q);
        live_d    = live_q - 1'b1;
      end
      S_FREE: begin
        if (out_free) begin
          ld_out       = 1'b1;
          o_status     = ST_OK;
          sm_we_pos    = 1'b1;
          sm_waddr     = hs;
          sm_wdata.pos = POS_INVALID;
        end
      end
      default: ;
    endcase

    out_valid_d = ld_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LIMIT_MAX[SW-1:0];
      live_q      <= '0;
      hw_q        <= '0;
      fhead_q     <= '0;
      ftail_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      hw_q        <= hw_d;
      fhead_q     <= fhead_d;
      ftail_q     <= ftail_d;
      out_valid_q <= out_valid_d;
      if (live_limit_we_i) begin
        limit_q <= ({1'b0, live_limit_i} > LIMIT_MAX) ? LIMIT_MAX[SW-1:0] : live_limit_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= action_i;
      hdl_q <= handle_i;
      dep_q <= dependency_i;
      ent_q <= entry_ref_i;
      arg_q <= args_ref_i;
    end
    if (hole_ld) hole_q <= pos_cur[SW-1:0];
    if (ld_out) begin
      out_status_q <= o_status;
      out_handle_q <= o_handle;
      out_pos_q    <= o_pos;
      out_rec_q    <= o_rec;
    end
  end

  // Slot memory: one read, one write with per-field enables
  always_ff @(posedge clk_i) begin
    if (sm_we_gen) slot_mem[sm_waddr].gen <= sm_wdata.gen;
    if (sm_we_pos) slot_mem[sm_waddr].pos <= sm_wdata.pos;
    if (sm_we_nxt) slot_mem[sm_waddr].nxt <= sm_wdata.nxt;
    if (sm_re)     srd_q <= slot_mem[sm_raddr];
  end

  // Record memory
  always_ff @(posedge clk_i) begin
    if (rm_we) rec_mem[rm_waddr] <= rm_wdata;
    if (rm_re) rrd_q <= rec_mem[rm_raddr];
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign new_handle_o      = out_handle_q;
  assign packed_position_o = out_pos_q;
  assign dependency_out_o  = out_rec_q.dep;
  assign work_count_out_o  = out_rec_q.wc;
  assign entry_out_o       = out_rec_q.ent;
  assign args_out_o        = out_rec_q.arg;

  // Assertions
  `GHT_ASSERT_NOW(a_live_le_fill, 1'b1, live_q <= hw_q, "live count above fill mark")
  `GHT_ASSERT_NOW(a_freed_nonempty, hw_q == SLOTS_PW, live_q < hw_q, "no free slot left")
  `GHT_ASSERT_NEXT(a_move_shrinks, state_q == S_MOVE,
                   live_q == PW'($past(live_q) - 1'b1), "delete did not shrink live count")

endmodule

// File: bench/handle_table_checker.sv
// ----------------------------------------------------------------------------
// Generational handle table checker
// Watches the config, input and output channels of the handle table, keeps a
// private copy of the slot map and packed record array, and compares every
// output transfer field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module handle_table_checker import ght_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned SW   = $clog2(SLOTS),
  localparam int unsigned PW   = $clog2(SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              live_limit_we_i,
  input  logic [SW-1:0]     live_limit_i,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [HDL_W-1:0]  handle_i,
  input  logic [HDL_W-1:0]  dependency_i,
  input  logic [REF_W-1:0]  entry_ref_i,
  input  logic [REF_W-1:0]  args_ref_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [1:0]        status_o,
  input  logic [HDL_W-1:0]  new_handle_o,
  input  logic [PW-1:0]     packed_position_o,
  input  logic [HDL_W-1:0]  dependency_out_o,
  input  logic [WC_W-1:0]   work_count_out_o,
  input  logic [REF_W-1:0]  entry_out_o,
  input  logic [REF_W-1:0]  args_out_o,
  output int unsigned       mismatch_count,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       status;
    logic [HDL_W-1:0] new_handle;
    logic [PW-1:0]    position;
    logic [HDL_W-1:0] dependency;
    logic [WC_W-1:0]  work_count;
    logic [REF_W-1:0] entry;
    logic [REF_W-1:0] args;
  } table_reply_t;

  // slot side
  logic [GEN_W-1:0] slot_gen   [SLOTS];
  int unsigned      slot_link  [SLOTS];
  int unsigned      slot_index [SLOTS];
  // packed record side
  int unsigned      rec_owner  [SLOTS];
  logic [HDL_W-1:0] rec_dep    [SLOTS];
  logic [WC_W-1:0]  rec_work   [SLOTS];
  logic [REF_W-1:0] rec_entry  [SLOTS];
  logic [REF_W-1:0] rec_args   [SLOTS];

  int unsigned live_records;
  int unsigned free_first;
  int unsigned free_last;
  int unsigned record_cap;

  table_reply_t replies_due[$];
  int unsigned  errors = 0;

  assign mismatch_count = errors;

  function automatic int unsigned clamp_slot(int unsigned s);
    return (s < SLOTS) ? s : 0;
  endfunction

  // SLOTS when the handle does not name a live record
  function automatic int unsigned find_live_slot(logic [HDL_W-1:0] h);
    int unsigned s;
    s = h[HSLOT_W-1:0];
    if (s >= SLOTS) return SLOTS;
    if (slot_gen[s] != h[GEN_LSB +: GEN_W]) return SLOTS;
    if (slot_index[s] >= live_records) return SLOTS;
    return s;
  endfunction

  task automatic clear_table();
    for (int unsigned i = 0; i < SLOTS; i++) begin
      slot_gen[i]   = '0;
      slot_link[i]  = i + 1;
      slot_index[i] = SLOTS;
      rec_owner[i]  = 0;
      rec_dep[i]    = '0;
      rec_work[i]   = '0;
      rec_entry[i]  = '0;
      rec_args[i]   = '0;
    end
    live_records = 0;
    free_first   = 0;
    free_last    = SLOTS - 1;
    record_cap   = SLOTS - 1;
  endtask

  function automatic table_reply_t table_update(logic [1:0] act, logic [HDL_W-1:0] h,
                                                logic [HDL_W-1:0] dep,
                                                logic [REF_W-1:0] ent,
                                                logic [REF_W-1:0] arg);
    table_reply_t r;
    int unsigned  s;
    int unsigned  p;
    int unsigned  last;
    int unsigned  mover;
    r          = '0;
    r.status   = ST_NOT_FOUND;
    r.position = PW'(SLOTS);
    case (act)
      ACT_ALLOC: begin
        if (live_records >= record_cap || live_records >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          s           = clamp_slot(free_first);
          p           = live_records;
          free_first  = clamp_slot(slot_link[s]);
          slot_gen[s] = slot_gen[s] + 1'b1;
          slot_index[s] = p;
          rec_owner[p]  = s;
          rec_entry[p]  = ent;
          rec_args[p]   = arg;
          rec_work[p]   = WORK_INIT;
          rec_dep[p]    = dep;
          live_records  = p + 1;
          r.status      = ST_OK;
          r.new_handle  = {HANDLE_KIND, slot_gen[s], HSLOT_W'(s)};
        end
      end
      ACT_DELETE: begin
        s = find_live_slot(h);
        if (s < SLOTS) begin
          p    = slot_index[s];
          last = live_records - 1;
          // last record fills the hole
          rec_entry[p] = rec_entry[last];
          rec_args[p]  = rec_args[last];
          rec_work[p]  = rec_work[last];
          rec_dep[p]   = rec_dep[last];
          rec_owner[p] = rec_owner[last];
          mover        = clamp_slot(rec_owner[p]);
          slot_index[mover] = p;
          live_records = last;
          slot_index[s] = SLOTS;
          slot_link[clamp_slot(free_last)] = s;
          free_last    = s;
          r.status     = ST_OK;
        end
      end
      ACT_LOOKUP: begin
        s = find_live_slot(h);
        if (s < SLOTS) begin
          p            = slot_index[s];
          r.status     = ST_OK;
          r.position   = PW'(p);
          r.dependency = rec_dep[p];
          r.work_count = rec_work[p];
          r.entry      = rec_entry[p];
          r.args       = rec_args[p];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void match_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors < 100)
        $display("%0t ns: %s expected 'h%0h, got 'h%0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_reply_t want;
    int unsigned  cap;
    if (!rst_ni) begin
      clear_table();
      replies_due.delete();
      outstanding <= 0;
    end else begin
      if (live_limit_we_i) begin
        cap        = live_limit_i;
        record_cap = (cap > SLOTS - 1) ? SLOTS - 1 : cap;
      end
      // retire before predicting, a reply never belongs to a same-edge input
      if (out_valid_o && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors < 100)
            $display("%0t ns: output transfer with no reply due, status %0d handle 'h%0h",
                     $time, status_o, new_handle_o);
        end else begin
          want = replies_due.pop_front();
          match_field("status", 64'(want.status), 64'(status_o));
          match_field("new_handle", 64'(want.new_handle), 64'(new_handle_o));
          match_field("packed_position", 64'(want.position), 64'(packed_position_o));
          match_field("dependency_out", 64'(want.dependency), 64'(dependency_out_o));
          match_field("work_count_out", 64'(want.work_count), 64'(work_count_out_o));
          match_field("entry_out", want.entry, entry_out_o);
          match_field("args_out", want.args, args_out_o);
        end
      end
      if (in_valid_i && !in_stall_o)
        replies_due.push_back(table_update(action_i, handle_i, dependency_i,
                                           entry_ref_i, args_ref_i));
      outstanding <= replies_due.size();
    end
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Generational handle table testbench
// Drives allocate, delete and lookup traffic with random gaps and output
// stalls over several live limits, including a large table fill; handles come
// from observed replies. Prediction and comparison live in the checker.
// ----------------------------------------------------------------------------
module testbench import ght_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TB_SLOTS   = SLOTS_DEF;
  localparam int unsigned SW         = $clog2(TB_SLOTS);
  localparam int unsigned PW         = $clog2(TB_SLOTS + 1);
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              live_limit_we_i;
  logic [SW-1:0]     live_limit_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [HDL_W-1:0]  handle_i;
  logic [HDL_W-1:0]  dependency_i;
  logic [REF_W-1:0]  entry_ref_i;
  logic [REF_W-1:0]  args_ref_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [HDL_W-1:0]  new_handle_o;
  logic [PW-1:0]     packed_position_o;
  logic [HDL_W-1:0]  dependency_out_o;
  logic [WC_W-1:0]   work_count_out_o;
  logic [REF_W-1:0]  entry_out_o;
  logic [REF_W-1:0]  args_out_o;
  int unsigned       mismatch_count;
  int unsigned       outstanding;

  logic [HDL_W-1:0]  live_handles[$];
  logic [HDL_W-1:0]  retired_handles[$];
  bit                quiet_in;
  bit                quiet_out;
  int unsigned       holds_asked = 0;
  int unsigned       holds_taken = 0;
  int unsigned       stall_left = 0;
  int unsigned       quiet_cycles;

  generational_handle_table_top #(.SLOTS(TB_SLOTS)) dut (.*);

  handle_table_checker #(.SLOTS(TB_SLOTS)) table_monitor (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random stalls, an occasional long hold, handle harvesting
  always @(posedge clk_i) begin : receiver
    int unsigned r;
    if (out_valid_o && !out_stall_i && status_o == ST_OK && new_handle_o != '0)
      live_handles.push_back(new_handle_o);
    if (holds_taken != holds_asked) begin
      holds_taken = holds_asked;
      stall_left  = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_out || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left  = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        live_limit_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL generational_handle_table_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [REF_W-1:0] rand_ref();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // valid stays high into the next item when there is no gap
  task automatic send_item(logic [1:0] act, logic [HDL_W-1:0] h, logic [HDL_W-1:0] dep,
                           logic [REF_W-1:0] ent, logic [REF_W-1:0] arg);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    handle_i     <= h;
    dependency_i <= dep;
    entry_ref_i  <= ent;
    args_ref_i   <= arg;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic probe(logic [1:0] act, logic [HDL_W-1:0] h);
    send_item(act, h, $urandom, rand_ref(), rand_ref());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [SW-1:0] v);
    live_limit_we_i <= 1'b1;
    live_limit_i    <= v;
    @(posedge clk_i);
    live_limit_we_i <= 1'b0;
  endtask

  task automatic retire(logic [HDL_W-1:0] h);
    retired_handles.push_back(h);
    if (retired_handles.size() > 64) void'(retired_handles.pop_front());
  endtask

  task automatic do_alloc();
    send_item(ACT_ALLOC, $urandom, $urandom, rand_ref(), rand_ref());
  endtask

  task automatic do_delete();
    int unsigned      idx;
    logic [HDL_W-1:0] h;
    if (live_handles.size() == 0) begin
      do_alloc();
    end else begin
      idx = $urandom_range(0, live_handles.size() - 1);
      h   = live_handles[idx];
      live_handles.delete(idx);
      retire(h);
      // type nibble is ignored by the block
      if ($urandom_range(0, 3) == 0) h[TYPE_LSB +: TYPE_W] = 4'($urandom);
      probe(ACT_DELETE, h);
    end
  endtask

  task automatic do_lookup();
    logic [HDL_W-1:0] h;
    if (live_handles.size() == 0) begin
      h = $urandom;
    end else begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      if ($urandom_range(0, 3) == 0) h[TYPE_LSB +: TYPE_W] = 4'($urandom);
    end
    probe(ACT_LOOKUP, h);
  endtask

  task automatic do_noise();
    logic [HDL_W-1:0] h;
    logic [1:0]       act;
    h   = $urandom;
    act = ($urandom_range(0, 1) != 0) ? ACT_DELETE : ACT_LOOKUP;
    case ($urandom_range(0, 4))
      0: act = ACT_UNUSED;
      1: if (retired_handles.size() > 0)
           h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
      2: h[HSLOT_W-1:0] = HSLOT_W'($urandom_range(TB_SLOTS, 16'hFFFF));
      3: if (live_handles.size() > 0)
           h = live_handles[$urandom_range(0, live_handles.size() - 1)] ^
               (HDL_W'($urandom_range(1, 4095)) << GEN_LSB);
      default: ;
    endcase
    probe(act, h);
  endtask

  task automatic run_mix(int unsigned n, int unsigned alloc_pct, int unsigned delete_pct);
    int unsigned r;
    quiet_in  = ($urandom_range(0, 3) == 0);
    quiet_out = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) do_alloc();
      else if (r < alloc_pct + delete_pct) do_delete();
      else if (r < 93) do_lookup();
      else do_noise();
    end
    wait_idle();
  endtask

  initial begin : stimulus
    logic [HDL_W-1:0] h0, h1, h2;
    rst_ni          = 1'b0;
    live_limit_we_i = 1'b0;
    live_limit_i    = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_ALLOC;
    handle_i        = '0;
    dependency_i    = '0;
    entry_ref_i     = '0;
    args_ref_i      = '0;
    quiet_in        = 1'b0;
    quiet_out       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, moves on delete, stale and out-of-range handles
    write_limit('1);
    send_item(ACT_ALLOC, '0, '0, '0, '0);
    send_item(ACT_ALLOC, '1, '1, '1, '1);
    do_alloc();
    wait_idle();
    h0 = live_handles[0];
    h1 = live_handles[1];
    h2 = live_handles[2];
    live_handles.delete();
    probe(ACT_LOOKUP, h0);
    probe(ACT_LOOKUP, {4'hF, h1[TYPE_LSB-1:0]});
    probe(ACT_LOOKUP, h2);
    probe(ACT_LOOKUP, {h0[HDL_W-1:HSLOT_W], 16'hFFFF});
    probe(ACT_LOOKUP, {h0[HDL_W-1:HSLOT_W], HSLOT_W'(TB_SLOTS)});
    probe(ACT_LOOKUP, h0 ^ 32'h0001_0000);
    probe(ACT_UNUSED, h0);
    probe(ACT_LOOKUP, {HANDLE_KIND, 12'd0, 16'd500});   // free slot, generation zero
    probe(ACT_DELETE, {h0[HDL_W-1:HSLOT_W], 16'hFFFF});
    probe(ACT_DELETE, h0);                            // last record moves into the hole
    probe(ACT_LOOKUP, h2);
    probe(ACT_DELETE, h0);
    probe(ACT_LOOKUP, h0);
    probe(ACT_DELETE, h1);                            // hole is the last record
    probe(ACT_DELETE, h2);
    probe(ACT_LOOKUP, 32'h0FFF_0000);
    retire(h0);
    retire(h1);
    retire(h2);
    wait_idle();
    write_limit('0);
    do_alloc();
    wait_idle();
    write_limit(SW'(1));
    do_alloc();
    do_alloc();
    wait_idle();

    // random traffic over several limits
    run_mix(50, 50, 20);
    write_limit(SW'(2));
    run_mix(50, 45, 25);
    write_limit(SW'($urandom_range(3, 40)));
    run_mix(40, 45, 25);
    quiet_in = 1'b1;
    holds_asked++;
    repeat (40) do_alloc();
    wait_idle();
    run_mix(80, 45, 25);

    // grow the table to a few hundred records, then churn and drain
    write_limit('1);
    quiet_in = ($urandom_range(0, 1) != 0);
    repeat (300) do_alloc();
    wait_idle();
    run_mix(100, 10, 50);
    write_limit(SW'(5));
    run_mix(60, 25, 55);
    write_limit('1);
    run_mix(80, 40, 25);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS generational_handle_table_top");
    end else begin
      $display("FAIL generational_handle_table_top");
    end
    $finish;
  end

endmodule
